// ===== sv/isr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isr_pkg
// shared constants, types and codes of the ising ring spin update block
// ----------------------------------------------------------------------------
package isr_pkg;

  localparam int RING_SPINS = 64;
  localparam int ADDR_W     = (RING_SPINS > 1) ? $clog2(RING_SPINS) : 1;
  localparam int EXT_W      = (ADDR_W > 6) ? ADDR_W + 1 : 7;

  localparam int SITE_W     = 6;
  localparam int DRAW_W     = 16;
  localparam int THR_W      = 17;
  localparam int CFG_W      = 17;
  localparam int TOT_W      = 8;
  localparam int NUM_THR    = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USED_W = 2 + 2 * TOT_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(65536);
  localparam logic [TOT_W-1:0] TOT_RESET = TOT_W'(RING_SPINS);

  localparam logic MODE_METROPOLIS = 1'b1;
  localparam logic MODE_GIBBS      = 1'b0;
  localparam logic CMD_UPDATE      = 1'b0;
  localparam logic CMD_WRITE       = 1'b1;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_UP_NEG2,
    REG_UP_ZERO,
    REG_UP_POS2,
    REG_DN_NEG2,
    REG_DN_ZERO,
    REG_DN_POS2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SITE,
    S_EXEC
  } seq_state_t;

  typedef struct packed {
    logic                          mode;
    logic [NUM_THR-1:0][THR_W-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [SITE_W-1:0] site;
    logic              spin_value;
    logic [DRAW_W-1:0] draw;
  } item_t;

  typedef struct packed {
    logic              changed;
    logic              new_spin;
    logic [TOT_W-1:0]  magnetization;
    logic [TOT_W-1:0]  bond_sum;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_data;
  } ram_req_t;

endpackage
`default_nettype wire

// ===== sv/isr_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isr_cfg_regs
// update mode and the six acceptance thresholds, written by index
// ----------------------------------------------------------------------------
module isr_cfg_regs (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire isr_pkg::cfg_idx_t        cfg_index,
  input  wire logic [isr_pkg::CFG_W-1:0] cfg_wdata,
  output isr_pkg::cfg_t                 cfg
);
  import isr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODE:    cfg_nxt.mode   = cfg_wdata[0];
        REG_UP_NEG2: cfg_nxt.thr[0] = cfg_wdata[THR_W-1:0];
        REG_UP_ZERO: cfg_nxt.thr[1] = cfg_wdata[THR_W-1:0];
        REG_UP_POS2: cfg_nxt.thr[2] = cfg_wdata[THR_W-1:0];
        REG_DN_NEG2: cfg_nxt.thr[3] = cfg_wdata[THR_W-1:0];
        REG_DN_ZERO: cfg_nxt.thr[4] = cfg_wdata[THR_W-1:0];
        REG_DN_POS2: cfg_nxt.thr[5] = cfg_wdata[THR_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= MODE_METROPOLIS;
      cfg_r.thr  <= {NUM_THR{THR_RESET}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== sv/isr_spin_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isr_spin_ram
// spin memory, one write and two registered reads, unwritten entries read +1
// ----------------------------------------------------------------------------
module isr_spin_ram (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire isr_pkg::ram_req_t req,
  output logic                   rd_a,
  output logic                   rd_b
);
  import isr_pkg::*;

  logic                  mem [0:RING_SPINS-1];
  logic [RING_SPINS-1:0] vld_r;
  logic                  rd_a_r;
  logic                  rd_b_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_a_r <= vld_r[req.rd_a_addr] ? mem[req.rd_a_addr] : 1'b1;
    rd_b_r <= vld_r[req.rd_b_addr] ? mem[req.rd_b_addr] : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule
`default_nettype wire

// ===== sv/isr_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isr_seq
// site sequencer: neighbor and site reads, decision, write back, totals
// ----------------------------------------------------------------------------
module isr_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire isr_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire isr_pkg::item_t    in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output isr_pkg::result_t       out_res,
  output isr_pkg::ram_req_t      ram_req,
  input  wire logic              rd_a,
  input  wire logic              rd_b
);
  import isr_pkg::*;

  seq_state_t       state_r, state_nxt;
  item_t            item_r;
  logic             left_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;
  logic [TOT_W-1:0] mag_r, mag_nxt;
  logic [TOT_W-1:0] bond_r, bond_nxt;

  logic [EXT_W-1:0] site_ext;
  logic [EXT_W-1:0] left_ext;
  logic [EXT_W-1:0] right_ext;
  logic             in_ring;
  logic             old_bit;
  logic [1:0]       col;
  logic [2:0]       sel;
  logic             pass;
  logic             dec_bit;
  logic             new_bit;
  logic             chg;
  logic [TOT_W-1:0] mag_delta;
  logic [TOT_W-1:0] bond_delta;
  logic             retire;

  always_comb begin
    site_ext  = EXT_W'(item_r.site);
    in_ring   = site_ext < EXT_W'(RING_SPINS);
    left_ext  = (site_ext == '0) ? EXT_W'(RING_SPINS - 1) : site_ext - EXT_W'(1);
    right_ext = (site_ext + EXT_W'(1) == EXT_W'(RING_SPINS)) ? '0 : site_ext + EXT_W'(1);

    old_bit = rd_a;
    col     = {1'b0, left_r} + {1'b0, rd_b};
    sel     = (old_bit ? 3'd0 : 3'd3) + {1'b0, col};
    pass    = cfg.thr[sel] > {1'b0, item_r.draw};

    if (cfg.mode == MODE_METROPOLIS) begin
      dec_bit = pass ? ~old_bit : old_bit;
    end else begin
      dec_bit = pass;
    end
    new_bit = (item_r.command == CMD_WRITE) ? item_r.spin_value : dec_bit;
    chg     = in_ring && (new_bit != old_bit);

    mag_delta = new_bit ? TOT_W'(2) : TOT_W'(-2);
    if (left_r != rd_b) begin
      bond_delta = '0;
    end else begin
      bond_delta = (new_bit == left_r) ? TOT_W'(4) : TOT_W'(-4);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    mag_nxt       = mag_r;
    bond_nxt      = bond_r;
    retire        = 1'b0;

    ram_req.rd_a_addr = left_ext[ADDR_W-1:0];
    ram_req.rd_b_addr = right_ext[ADDR_W-1:0];
    ram_req.wr_en     = 1'b0;
    ram_req.wr_addr   = site_ext[ADDR_W-1:0];
    ram_req.wr_data   = new_bit;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_SITE;
      end
      S_SITE: begin
        ram_req.rd_a_addr = site_ext[ADDR_W-1:0];
        state_nxt         = S_EXEC;
      end
      S_EXEC: begin
        // keep the site bit on port a while the result slot is full
        ram_req.rd_a_addr = site_ext[ADDR_W-1:0];
        if (!out_valid_r || out_ready) begin
          retire           = 1'b1;
          ram_req.wr_en    = chg;
          out_valid_nxt    = 1'b1;
          res_nxt.changed  = chg;
          res_nxt.new_spin = in_ring && new_bit;
          if (chg) begin
            mag_nxt  = mag_r + mag_delta;
            bond_nxt = bond_r + bond_delta;
          end
          res_nxt.magnetization = mag_nxt;
          res_nxt.bond_sum      = bond_nxt;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mag_r       <= TOT_RESET;
      bond_r      <= TOT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mag_r       <= mag_nxt;
      bond_r      <= bond_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    if (state_r == S_SITE) begin
      left_r <= rd_a;
    end
    res_r <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_wr_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> (state_r == S_EXEC && retire))
    else $error("spin write outside execute step");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result appeared without an executed item");

  a_totals_need_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && mag_r != $past(mag_r)) |-> $past(ram_req.wr_en))
    else $error("magnetization moved without a spin change");

  a_exec_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && out_valid_r && !out_ready) |=> state_r == S_EXEC)
    else $error("item left execute while result slot was full");

endmodule
`default_nettype wire

// ===== sv/ising_ring_spin_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ising_ring_spin_update
// ring of spins with metropolis or heat-bath single site updates
// ----------------------------------------------------------------------------
// Each item is an update attempt or a spin write at one site and gives
// exactly one result with the new spin and the running magnetization and
// bond sum. After acceptance the spin memory is read for both neighbors,
// then for the site itself, and the decision and write back follow in the
// execute step; the next item is accepted only once the block is back in
// idle, so items do not overlap. A finished result waits in the output
// register; the next item is still accepted but holds in its execute step
// until that result is taken. Sites beyond the ring leave all state
// untouched. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ising_ring_spin_update (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // site[5:0], spin_value[6], random_draw[22:7], zero pad
  input  wire logic [isr_pkg::IN_DATA_W-1:0] in_tdata,
  // command[0]
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // changed[0], new_spin[1], magnetization[9:2], bond_sum[17:10], zero pad
  output logic [isr_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                          cfg_wr_en,
  input  wire isr_pkg::cfg_idx_t             cfg_index,
  input  wire logic [isr_pkg::CFG_W-1:0]     cfg_wdata
);
  import isr_pkg::*;

  cfg_t     cfg;
  item_t    in_item;
  result_t  out_res;
  ram_req_t ram_req;
  logic     rd_a;
  logic     rd_b;

  assign in_item.command    = in_tuser;
  assign in_item.site       = in_tdata[SITE_W-1:0];
  assign in_item.spin_value = in_tdata[SITE_W];
  assign in_item.draw       = in_tdata[SITE_W+DRAW_W:SITE_W+1];

  assign out_tdata = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, out_res.bond_sum,
                      out_res.magnetization, out_res.new_spin, out_res.changed};

  isr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  isr_spin_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rd_a  (rd_a),
    .rd_b  (rd_b)
  );

  isr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .ram_req   (ram_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

endmodule
`default_nettype wire
